### design/anti_replay_counter_table_top_assert.svh
// assertion macros for the anti-replay counter table
`ifndef ANTI_REPLAY_COUNTER_TABLE_TOP_ASSERT_SVH
`define ANTI_REPLAY_COUNTER_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ARCT_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arct assertion failed");

// next-cycle implication
`define ARCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arct assertion failed");

// implication with a delayed consequent
`define ARCT_ASSERT_AFTER2(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("arct assertion failed");

`endif

### design/arct_pkg.sv
// shared types and constants of the anti-replay counter table
package arct_pkg;

  localparam int unsigned MAX_ADDRESS_DEF    = 247;
  localparam int unsigned NUM_DIRECTIONS_DEF = 3;

  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CTR_W   = 32;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  // outgoing counter advances by one per 16-byte block
  localparam int unsigned BLOCK_MASK  = 15;
  localparam int unsigned BLOCK_SHIFT = 4;
  localparam int unsigned BLK_W       = LEN_W + 1 - BLOCK_SHIFT;

  typedef enum logic [REQ_W-1:0] {
    REQ_RESET = 2'd0,
    REQ_OUT   = 2'd1,
    REQ_IN    = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_REPLAY     = 2'd1,
    STATUS_BELOW_INIT = 2'd2,
    STATUS_BAD_ADDR   = 2'd3
  } status_e;

  typedef struct packed {
    logic out_vld;
    logic in_vld;
  } vld_t;

  typedef struct packed {
    logic [CTR_W-1:0] out_ctr;
    logic [CTR_W-1:0] in_mark;
  } cnt_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

### design/arct_ram.sv
// generic simple dual-port ram with registered read
module arct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/arct_ctrl.sv
// sequencer: clearing pass, then idle and an execute state for each item
module arct_ctrl import arct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy,
  output logic      done_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
      unique case (state_q)
        S_CLEAR: begin
          if (stat_i.clear_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.clear = (state_q == S_CLEAR);
    cmd_o.load  = (state_q == S_IDLE) && start;
    cmd_o.exec  = (state_q == S_EXEC);
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

### design/arct_dp.sv
// datapath: item registers, table rams, update logic and result registers
module arct_dp import arct_pkg::*; #(
  parameter int unsigned MaxAddress    = MAX_ADDRESS_DEF,
  parameter int unsigned NumDirections = NUM_DIRECTIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ADDR_W-1:0] slave_addr_i,
  input  logic [DIR_W-1:0]  direction_i,
  input  logic [LEN_W-1:0]  msg_length_i,
  input  logic [CTR_W-1:0]  counter_in_i,
  input  logic [CTR_W-1:0]  initial_counter_i,
  output logic [STAT_W-1:0] status_o,
  output logic [CTR_W-1:0]  counter_out_o
);

  localparam int unsigned Depth = (MaxAddress + 1) * NumDirections;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned VldW  = $bits(vld_t);
  localparam int unsigned CntW  = $bits(cnt_t);

  // item registers
  req_e             kind_q;
  logic             bad_q;
  logic [IdxW-1:0]  idx_q;
  logic [LEN_W-1:0] len_q;
  logic [CTR_W-1:0] ctr_q;
  logic [CTR_W-1:0] seed_q;

  logic [IdxW-1:0]  clr_cnt_q;
  logic [STAT_W-1:0] status_q;
  logic [CTR_W-1:0]  counter_q;

  logic             bad_in;
  logic [IdxW-1:0]  idx_in;
  logic [IdxW-1:0]  raddr;

  logic [VldW-1:0]  vld_rdata;
  logic [CntW-1:0]  cnt_rdata;
  vld_t             vld_rd;
  cnt_t             cnt_rd;
  vld_t             vld_wr;
  cnt_t             cnt_wr;
  status_e          st;
  logic [CTR_W-1:0] res;
  logic [CTR_W-1:0] base;
  logic             upd;
  logic [LEN_W:0]   len_sum;
  logic [BLK_W-1:0] blk;

  logic             vld_we;
  logic [IdxW-1:0]  vld_waddr;
  logic [VldW-1:0]  vld_wdata;
  logic             cnt_we;

  assign bad_in = (slave_addr_i > ADDR_W'(MaxAddress))
               || ({1'b0, direction_i} >= (DIR_W + 1)'(NumDirections));
  assign idx_in = IdxW'(slave_addr_i) * IdxW'(NumDirections) + IdxW'(direction_i);
  assign raddr  = bad_in ? '0 : idx_in;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_e'(req_type_i);
      bad_q  <= bad_in;
      idx_q  <= raddr;
      len_q  <= msg_length_i;
      ctr_q  <= counter_in_i;
      seed_q <= initial_counter_i;
    end
    if (cmd_i.exec) begin
      status_q  <= st;
      counter_q <= res;
    end
  end

  // clearing pass over the valid bits after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == IdxW'(Depth - 1));

  assign vld_rd = vld_t'(vld_rdata);
  assign cnt_rd = cnt_t'(cnt_rdata);

  // zero length still reserves one block
  assign len_sum = {1'b0, len_q} + (LEN_W + 1)'(BLOCK_MASK);
  assign blk     = (len_q == '0) ? BLK_W'(1) : BLK_W'(len_sum >> BLOCK_SHIFT);
  assign base    = vld_rd.out_vld ? cnt_rd.out_ctr : seed_q;

  always_comb begin
    vld_wr = vld_rd;
    cnt_wr = cnt_rd;
    st     = STATUS_OK;
    res    = '0;
    upd    = 1'b0;
    if (bad_q) begin
      st = STATUS_BAD_ADDR;
    end else begin
      unique case (kind_q)
        REQ_RESET: begin
          upd    = 1'b1;
          vld_wr = '0;
        end
        REQ_OUT: begin
          upd            = 1'b1;
          res            = base;
          cnt_wr.out_ctr = base + CTR_W'(blk);
          vld_wr.out_vld = 1'b1;
        end
        REQ_IN: begin
          upd = 1'b1;
          if (!vld_rd.in_vld) begin
            if (ctr_q < seed_q) begin
              st = STATUS_BELOW_INIT;
            end else begin
              cnt_wr.in_mark = ctr_q;
              vld_wr.in_vld  = 1'b1;
            end
          end else if (ctr_q < cnt_rd.in_mark) begin
            st = STATUS_REPLAY;
          end else begin
            cnt_wr.in_mark = ctr_q;
          end
        end
        default: begin
          upd = 1'b0;
        end
      endcase
    end
  end

  assign vld_we    = cmd_i.clear | (cmd_i.exec & upd);
  assign vld_waddr = cmd_i.clear ? clr_cnt_q : idx_q;
  assign vld_wdata = cmd_i.clear ? '0 : VldW'(vld_wr);
  assign cnt_we    = cmd_i.exec & upd;

  arct_ram #(
    .Width (VldW),
    .Depth (Depth)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .raddr_i (raddr),
    .rdata_o (vld_rdata)
  );

  arct_ram #(
    .Width (CntW),
    .Depth (Depth)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx_q),
    .wdata_i (CntW'(cnt_wr)),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  assign status_o      = status_q;
  assign counter_out_o = counter_q;

endmodule

### design/anti_replay_counter_table_top.sv
// top level of the anti-replay counter table
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   request   | start / busy         | req_type_i slave_addr_i direction_i
//             |                      | msg_length_i counter_in_i initial_counter_i
//   result    | done_o (one cycle)   | status_o counter_out_o
//
// an item is taken at an edge with start high and busy low; its result
// shows on done_o after the execute state, and busy is already low in the
// strobe cycle, so a new item can be taken while its result is shown
// in between lies the read-modify-write of one table entry through the
// registered read port of the table rams
// after reset busy stays high while the valid bits of all
// (MaxAddress+1)*NumDirections entries (744 by default) are cleared, one entry a cycle
// the receiver cannot stall: each result is valid for its strobe cycle only
`include "anti_replay_counter_table_top_assert.svh"

module anti_replay_counter_table_top import arct_pkg::*; #(
  parameter int unsigned MaxAddress    = MAX_ADDRESS_DEF,
  parameter int unsigned NumDirections = NUM_DIRECTIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ADDR_W-1:0] slave_addr_i,
  input  logic [DIR_W-1:0]  direction_i,
  input  logic [LEN_W-1:0]  msg_length_i,
  input  logic [CTR_W-1:0]  counter_in_i,
  input  logic [CTR_W-1:0]  initial_counter_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CTR_W-1:0]  counter_out_o
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: clearing pass, then idle / execute per item
  arct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // datapath: entry index, table rams and the update of one entry
  arct_dp #(
    .MaxAddress    (MaxAddress),
    .NumDirections (NumDirections)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .slave_addr_i      (slave_addr_i),
    .direction_i       (direction_i),
    .msg_length_i      (msg_length_i),
    .counter_in_i      (counter_in_i),
    .initial_counter_i (initial_counter_i),
    .status_o          (status_o),
    .counter_out_o     (counter_out_o)
  );

  // an accepted item keeps the block busy for its execute cycle
  `ARCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // every accepted item gives its result on done_o once its execute state has passed
  `ARCT_ASSERT_AFTER2(a_accept_done, start && !busy, done_o)
  // the block is ready again while a result is shown
  `ARCT_ASSERT_IMPLIES(a_done_ready, done_o, !busy)
  // any error status carries a zero counter
  `ARCT_ASSERT_IMPLIES(a_err_zero, done_o && (status_o != STATUS_OK), counter_out_o == '0)

endmodule

### tb/anti_replay_counter_table_top_tb.sv
// testbench for the anti-replay counter table: directed and random requests against a scoreboard
module anti_replay_counter_table_top_tb;
  import arct_pkg::*;

  localparam int unsigned ENTRIES = (MAX_ADDRESS_DEF + 1) * NUM_DIRECTIONS_DEF;

  // request code with no function, and the direction codes
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [DIR_W-1:0] DIR_M2S    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_S2M    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BCAST  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BAD    = 2'd3;

  // reset clearing pass plus longest sender gap, taken several times over
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned HOT_ENTRIES  = 6;

  typedef struct packed {
    status_e          status;
    logic [CTR_W-1:0] ctr;
  } reply_t;

  // mirror of the counter table and the queue of replies it predicts
  class counter_table_sb;
    bit               out_vld [ENTRIES];
    logic [CTR_W-1:0] out_ctr [ENTRIES];
    bit               in_vld  [ENTRIES];
    logic [CTR_W-1:0] in_mark [ENTRIES];
    reply_t           replies_q [$];
    int unsigned      errors;

    function new();
      errors = 0;
      foreach (out_vld[i]) begin
        out_vld[i] = 1'b0;
        in_vld[i]  = 1'b0;
        out_ctr[i] = '0;
        in_mark[i] = '0;
      end
    endfunction

    // update the table for an accepted item and queue its reply
    function void note_item(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            logic [DIR_W-1:0] dir, logic [LEN_W-1:0] len,
                            logic [CTR_W-1:0] ctr, logic [CTR_W-1:0] seed);
      reply_t         r;
      int unsigned    idx;
      logic [LEN_W:0] blocks;
      r.status = STATUS_OK;
      r.ctr    = '0;
      if (addr > MAX_ADDRESS_DEF || dir >= NUM_DIRECTIONS_DEF) begin
        r.status = STATUS_BAD_ADDR;
      end else begin
        idx = addr * NUM_DIRECTIONS_DEF + dir;
        case (kind)
          REQ_RESET: begin
            out_vld[idx] = 1'b0;
            in_vld[idx]  = 1'b0;
          end
          REQ_OUT: begin
            blocks = (LEN_W + 1)'(({1'b0, len} + BLOCK_MASK) >> BLOCK_SHIFT);
            if (blocks == 0) blocks = (LEN_W + 1)'(1);
            if (!out_vld[idx]) begin
              out_ctr[idx] = seed;
              out_vld[idx] = 1'b1;
            end
            r.ctr        = out_ctr[idx];
            out_ctr[idx] = r.ctr + CTR_W'(blocks);
          end
          REQ_IN: begin
            if (!in_vld[idx]) begin
              if (ctr < seed) begin
                r.status = STATUS_BELOW_INIT;
              end else begin
                in_mark[idx] = ctr;
                in_vld[idx]  = 1'b1;
              end
            end else if (ctr < in_mark[idx]) begin
              r.status = STATUS_REPLAY;
            end else if (ctr > in_mark[idx]) begin
              in_mark[idx] = ctr;
            end
          end
          default: begin
          end
        endcase
      end
      replies_q.push_back(r);
    endfunction

    // compare one result with the oldest queued reply
    function void check_result(logic [STAT_W-1:0] status, logic [CTR_W-1:0] ctr);
      reply_t want;
      if (replies_q.size() == 0) begin
        $error("unexpected result: status %0d counter_out %0h", status, ctr);
        errors++;
      end else begin
        want = replies_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (ctr !== want.ctr) begin
          $error("counter_out: expected %0h, actual %0h", want.ctr, ctr);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return replies_q.size();
    endfunction
  endclass

  // every block input starts at a known value
  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              start             = 1'b0;
  logic [REQ_W-1:0]  req_type_i        = REQ_RESET;
  logic [ADDR_W-1:0] slave_addr_i      = '0;
  logic [DIR_W-1:0]  direction_i       = DIR_M2S;
  logic [LEN_W-1:0]  msg_length_i      = '0;
  logic [CTR_W-1:0]  counter_in_i      = '0;
  logic [CTR_W-1:0]  initial_counter_i = '0;
  logic              busy;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [CTR_W-1:0]  counter_out_o;

  counter_table_sb   sb;
  bit                no_gaps;

  // a few entries get most of the traffic so sequences reach deep state
  logic [ADDR_W-1:0] hot_addr [HOT_ENTRIES];
  logic [DIR_W-1:0]  hot_dir  [HOT_ENTRIES];

  anti_replay_counter_table_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .slave_addr_i      (slave_addr_i),
    .direction_i       (direction_i),
    .msg_length_i      (msg_length_i),
    .counter_in_i      (counter_in_i),
    .initial_counter_i (initial_counter_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .counter_out_o     (counter_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // results cannot be held off: every strobe is checked at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.check_result(status_o, counter_out_o);
    end
  end

  // ends the run when neither side has moved for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && busy === 1'b0) || done_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // present one item, hold it until taken, then idle for a random gap unless no_gaps is set
  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                           input logic [DIR_W-1:0] dir, input logic [LEN_W-1:0] len,
                           input logic [CTR_W-1:0] ctr, input logic [CTR_W-1:0] seed);
    int unsigned gap;
    req_type_i        <= kind;
    slave_addr_i      <= addr;
    direction_i       <= dir;
    msg_length_i      <= len;
    counter_in_i      <= ctr;
    initial_counter_i <= seed;
    start             <= 1'b1;
    // busy stays high through the clearing pass after reset
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(kind, addr, dir, len, ctr, seed);
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every queued reply
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed traffic on hot entries, the rest raw noise
  task automatic random_item();
    int unsigned       pick;
    int unsigned       h;
    int unsigned       idx;
    int unsigned       delta;
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
    logic [DIR_W-1:0]  dir;
    logic [LEN_W-1:0]  len;
    logic [CTR_W-1:0]  ctr;
    logic [CTR_W-1:0]  seed;
    logic [CTR_W-1:0]  base;
    pick = $urandom_range(0, 99);
    len  = LEN_W'($urandom);
    ctr  = $urandom;
    seed = $urandom;
    if (pick < 80) begin
      h    = $urandom_range(0, HOT_ENTRIES - 1);
      addr = hot_addr[h];
      dir  = hot_dir[h];
      idx  = addr * NUM_DIRECTIONS_DEF + dir;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        kind = REQ_RESET;
      end else if (pick < 45) begin
        kind = REQ_OUT;
        if ($urandom_range(0, 3) != 0) len = LEN_W'($urandom_range(0, 100));
        // seeds near the top so the counter wraps now and then
        if ($urandom_range(0, 7) == 0) seed = ~CTR_W'($urandom_range(0, 255));
      end else begin
        kind = REQ_IN;
        // land around the mark, or around the seed on first use
        base  = sb.in_vld[idx] ? sb.in_mark[idx] : seed;
        delta = $urandom_range(0, 6);
        ctr   = base + delta - 3;
        if ($urandom_range(0, 9) == 0) ctr = base + $urandom_range(1, 1000);
      end
    end else begin
      kind = REQ_W'($urandom_range(0, 3));
      addr = ADDR_W'($urandom);
      dir  = DIR_W'($urandom);
    end
    send_item(kind, addr, dir, len, ctr, seed);
  endtask

  initial begin
    sb      = new();
    no_gaps = 1'b0;
    hot_addr[0] = '0;
    hot_dir[0]  = DIR_M2S;
    hot_addr[1] = ADDR_W'(MAX_ADDRESS_DEF);
    hot_dir[1]  = DIR_BCAST;
    for (int i = 2; i < HOT_ENTRIES; i++) begin
      hot_addr[i] = ADDR_W'($urandom_range(0, MAX_ADDRESS_DEF));
      hot_dir[i]  = DIR_W'($urandom_range(0, NUM_DIRECTIONS_DEF - 1));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bad address or direction for several request kinds
    send_item(REQ_OUT, 8'd248, DIR_M2S, 16'd16, 32'd0, 32'd0);
    send_item(REQ_IN, 8'd255, DIR_S2M, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(REQ_RESET, 8'd10, DIR_BAD, 16'd0, 32'd0, 32'd0);
    send_item(REQ_OUT, 8'd0, DIR_BAD, 16'd1, 32'd0, 32'd5);
    // unused request kind leaves the table alone
    send_item(REQ_UNUSED, 8'd3, DIR_M2S, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero length on first use, seeded at the top so the counter wraps
    send_item(REQ_OUT, 8'd0, DIR_M2S, 16'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(REQ_OUT, 8'd0, DIR_M2S, 16'hFFFF, 32'd0, 32'h0000_1234);
    send_item(REQ_OUT, 8'd0, DIR_M2S, 16'd17, 32'd0, 32'd0);
    send_item(REQ_OUT, 8'd247, DIR_BCAST, 16'd16, 32'd0, 32'hFFFF_FFF0);
    send_item(REQ_OUT, 8'd247, DIR_BCAST, 16'hFFFF, 32'd0, 32'd0);
    // incoming: below seed, seed, retry, replay, raise, replay
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd99, 32'd100);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd100, 32'd100);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd100, 32'd100);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd99, 32'd100);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd101, 32'hFFFF_FFFF);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd0, 32'd0);
    // reset request reopens seeding
    send_item(REQ_RESET, 8'd247, DIR_S2M, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'd0, 32'd0);
    send_item(REQ_IN, 8'd247, DIR_S2M, 16'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(REQ_RESET, 8'd0, DIR_M2S, 16'd0, 32'd0, 32'd0);
    send_item(REQ_OUT, 8'd0, DIR_M2S, 16'd1, 32'd0, 32'hAAAA_AAAA);
    send_item(REQ_IN, 8'd0, DIR_M2S, 16'd0, 32'd0, 32'd0);
    send_item(REQ_IN, 8'd248, DIR_M2S, 16'd0, 32'd5, 32'd0);
    send_item(REQ_RESET, 8'd255, DIR_BAD, 16'd0, 32'd0, 32'd0);

    // sender holds off until the table has answered everything
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stretches of back-to-back items between gapped ones
      no_gaps = ((n / 40) % 3) == 1;
      if (n % 90 == 89) begin
        hot_addr[n % HOT_ENTRIES] = ADDR_W'($urandom_range(0, MAX_ADDRESS_DEF));
        hot_dir[n % HOT_ENTRIES]  = DIR_W'($urandom_range(0, NUM_DIRECTIONS_DEF - 1));
      end
      random_item();
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
